FILE: hw/rtl/hsc_pkg.sv
package hsc_pkg;

    // Field widths of the converter samples and of the timestamp.
    localparam int ADC_BITS  = 12;
    localparam int TIME_BITS = 32;

    typedef logic [ADC_BITS-1:0]  adc_t;
    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [2:0]           hall_t;
    typedef logic [2:0]           step_t;
    typedef logic [1:0]           phase_t;

    // Event kinds carried by an input word.
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_STOP   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FWD_DIR     = 2'd0;
    localparam logic [1:0] CFG_VOLT_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_AMP_LIMIT   = 2'd2;

    // Hall codes that no rotor position produces.
    localparam hall_t HALL_ALL_LOW  = 3'b000;
    localparam hall_t HALL_ALL_HIGH = 3'b111;

    // Phase indexes.
    localparam phase_t PHASE_A = 2'd0;
    localparam phase_t PHASE_B = 2'd1;
    localparam phase_t PHASE_C = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_ALIGN = 3'd1,
        MODE_RUN   = 3'd2,
        MODE_STOP  = 3'd3,
        MODE_ERR   = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_OVERVOLT   = 3'd1,
        STATUS_OVERCURR   = 3'd2,
        STATUS_BAD_HALL   = 3'd3,
        STATUS_START_FAIL = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]     kind;
        hall_t          hall_code;
        time_t          time_us;
        adc_t [2:0]     volt;
        adc_t [2:0]     amp;
    } item_t;

    typedef struct packed {
        logic           forward_direction;
        adc_t           voltage_limit;
        adc_t           current_limit;
    } cfg_t;

    typedef struct packed {
        mode_t          mode;
        step_t          step;
        hall_t          prev_hall;
        time_t          prev_change_time;
        time_t          period;
    } state_t;

    typedef struct packed {
        status_t        status;
        mode_t          mode_now;
        step_t          step_now;
        phase_t         high_phase;
        phase_t         low_phase;
        logic           drive_on;
        time_t          period_us;
        logic           period_fresh;
    } result_t;

    // Forward hall sequence 3, 1, 5, 4, 6, 2 gives steps 0 to 5.
    function automatic step_t fwd_step(input hall_t code);
        step_t s;
        case (code)
            3'b011:  s = 3'd0;
            3'b001:  s = 3'd1;
            3'b101:  s = 3'd2;
            3'b100:  s = 3'd3;
            3'b110:  s = 3'd4;
            3'b010:  s = 3'd5;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    // Reverse direction runs the same sequence shifted by one step.
    function automatic step_t rev_step(input hall_t code);
        step_t s;
        case (code)
            3'b011:  s = 3'd5;
            3'b001:  s = 3'd0;
            3'b101:  s = 3'd1;
            3'b100:  s = 3'd2;
            3'b110:  s = 3'd3;
            3'b010:  s = 3'd4;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    // Phase switched to the positive rail in each step.
    function automatic phase_t high_of_step(input step_t s);
        phase_t p;
        case (s)
            3'd0, 3'd1: p = PHASE_A;
            3'd2, 3'd3: p = PHASE_B;
            3'd4, 3'd5: p = PHASE_C;
            default:    p = PHASE_A;
        endcase
        return p;
    endfunction

    // Phase switched to the negative rail in each step.
    function automatic phase_t low_of_step(input step_t s);
        phase_t p;
        case (s)
            3'd0, 3'd5: p = PHASE_B;
            3'd1, 3'd2: p = PHASE_C;
            3'd3, 3'd4: p = PHASE_A;
            default:    p = PHASE_A;
        endcase
        return p;
    endfunction

endpackage

FILE: hw/rtl/hsc_core.sv
module hsc_core (
    input  hsc_pkg::item_t   item,
    input  hsc_pkg::cfg_t    cfg,
    input  hsc_pkg::state_t  cur,
    output hsc_pkg::state_t  nxt,
    output hsc_pkg::result_t res
);

    hsc_pkg::status_t fault;
    hsc_pkg::status_t status;
    hsc_pkg::step_t   mapped_step;
    hsc_pkg::time_t   diff;
    logic             hall_ok;
    logic             drive;
    logic             fresh;

    // Fault scan: phase A wins over B over C, voltage over current in a phase.
    always_comb begin
        fault = hsc_pkg::STATUS_OK;
        for (int p = 2; p >= 0; p--) begin
            if (item.amp[p] > cfg.current_limit) begin
                fault = hsc_pkg::STATUS_OVERCURR;
            end
            if (item.volt[p] > cfg.voltage_limit) begin
                fault = hsc_pkg::STATUS_OVERVOLT;
            end
        end
    end

    // Hall decode and the wrapped time since the last change.
    always_comb begin
        hall_ok = (item.hall_code != hsc_pkg::HALL_ALL_LOW) &&
                  (item.hall_code != hsc_pkg::HALL_ALL_HIGH);
        mapped_step = cfg.forward_direction ? hsc_pkg::fwd_step(item.hall_code)
                                            : hsc_pkg::rev_step(item.hall_code);
        diff = item.time_us - cur.prev_change_time;
    end

    // Next state, with the status and drive decision of this word.
    always_comb begin
        nxt    = cur;
        status = hsc_pkg::STATUS_OK;
        fresh  = 1'b0;
        drive  = 1'b0;
        case (item.kind)
            hsc_pkg::KIND_START: begin
                nxt.step = '0;
                nxt.mode = hsc_pkg::MODE_ALIGN;
                drive    = 1'b1;
                if (hall_ok) begin
                    nxt.step             = mapped_step;
                    nxt.prev_hall        = item.hall_code;
                    nxt.prev_change_time = item.time_us;
                    nxt.mode             = hsc_pkg::MODE_RUN;
                end else begin
                    status = hsc_pkg::STATUS_START_FAIL;
                end
            end
            hsc_pkg::KIND_STOP: begin
                nxt.mode = hsc_pkg::MODE_STOP;
            end
            hsc_pkg::KIND_SAMPLE: begin
                if (cur.mode == hsc_pkg::MODE_RUN) begin
                    if (fault != hsc_pkg::STATUS_OK) begin
                        status   = fault;
                        nxt.mode = hsc_pkg::MODE_ERR;
                    end else begin
                        if (item.hall_code != cur.prev_hall) begin
                            if (diff != '0) begin
                                nxt.period = diff;
                                fresh      = 1'b1;
                            end
                            nxt.prev_change_time = item.time_us;
                            nxt.prev_hall        = item.hall_code;
                            if (hall_ok) begin
                                nxt.step = mapped_step;
                            end else begin
                                status   = hsc_pkg::STATUS_BAD_HALL;
                                nxt.mode = hsc_pkg::MODE_ERR;
                            end
                        end
                        drive = (nxt.mode == hsc_pkg::MODE_RUN);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Result word; the bridge outputs read as phase A when drive is off.
    always_comb begin
        res.status       = status;
        res.mode_now     = nxt.mode;
        res.step_now     = nxt.step;
        res.drive_on     = drive;
        res.high_phase   = drive ? hsc_pkg::high_of_step(nxt.step) : hsc_pkg::PHASE_A;
        res.low_phase    = drive ? hsc_pkg::low_of_step(nxt.step) : hsc_pkg::PHASE_A;
        res.period_us    = nxt.period;
        res.period_fresh = fresh;
    end

endmodule

FILE: hw/rtl/hall_six_step_commutator.sv
// Results are registered and flagged by m_valid. Throughput: one word per cycle unless
// a full result register waits on m_ready; the commutation state is updated as each
// word leaves the input register, so the next word sees it at once.
// Reset (synchronous, aresetn low): mode idle, step, last hall code, last change
// time and period zero, forward direction, both limits at full scale, no word held.
module hall_six_step_commutator (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [hsc_pkg::ADC_BITS-1:0]  cfg_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_kind,
    input  logic [2:0]                    s_hall_code,
    input  logic [hsc_pkg::TIME_BITS-1:0] s_time_us,
    input  logic [hsc_pkg::ADC_BITS-1:0]  s_volt_a,
    input  logic [hsc_pkg::ADC_BITS-1:0]  s_volt_b,
    input  logic [hsc_pkg::ADC_BITS-1:0]  s_volt_c,
    input  logic [hsc_pkg::ADC_BITS-1:0]  s_amp_a,
    input  logic [hsc_pkg::ADC_BITS-1:0]  s_amp_b,
    input  logic [hsc_pkg::ADC_BITS-1:0]  s_amp_c,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [2:0]                    m_mode_now,
    output logic [2:0]                    m_step_now,
    output logic [1:0]                    m_high_phase,
    output logic [1:0]                    m_low_phase,
    output logic                          m_drive_on,
    output logic [hsc_pkg::TIME_BITS-1:0] m_period_us,
    output logic                          m_period_fresh
);

    hsc_pkg::item_t   item_reg;
    logic             in_valid_reg;
    hsc_pkg::cfg_t    cfg_reg;
    hsc_pkg::state_t  state_reg;
    hsc_pkg::state_t  state_next;
    hsc_pkg::result_t result_reg;
    hsc_pkg::result_t result_next;
    logic             out_valid_reg;
    logic             advance;

    // The held word moves on when the result register is free or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            item_reg.kind      <= s_kind;
            item_reg.hall_code <= s_hall_code;
            item_reg.time_us   <= s_time_us;
            item_reg.volt      <= {s_volt_c, s_volt_b, s_volt_a};
            item_reg.amp       <= {s_amp_c, s_amp_b, s_amp_a};
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.forward_direction <= 1'b1;
            cfg_reg.voltage_limit     <= '1;
            cfg_reg.current_limit     <= '1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                hsc_pkg::CFG_FWD_DIR:    cfg_reg.forward_direction <= cfg_data[0];
                hsc_pkg::CFG_VOLT_LIMIT: cfg_reg.voltage_limit     <= cfg_data;
                hsc_pkg::CFG_AMP_LIMIT:  cfg_reg.current_limit     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    hsc_core u_core (
        .item (item_reg),
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    // Commutation state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode             <= hsc_pkg::MODE_IDLE;
            state_reg.step             <= '0;
            state_reg.prev_hall        <= '0;
            state_reg.prev_change_time <= '0;
            state_reg.period           <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = result_reg.status;
    assign m_mode_now     = result_reg.mode_now;
    assign m_step_now     = result_reg.step_now;
    assign m_high_phase   = result_reg.high_phase;
    assign m_low_phase    = result_reg.low_phase;
    assign m_drive_on     = result_reg.drive_on;
    assign m_period_us    = result_reg.period_us;
    assign m_period_fresh = result_reg.period_fresh;

`ifndef SYNTH
    // A driven step never ties one phase to both rails.
    a_phases_differ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_drive_on) |-> (m_high_phase != m_low_phase))
        else $error("driven step has the same high and low phase");

    // With the bridge off both phase outputs read as phase A.
    a_drive_off_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_drive_on) |->
        (m_high_phase == hsc_pkg::PHASE_A && m_low_phase == hsc_pkg::PHASE_A))
        else $error("phase outputs set while the bridge is off");

    // A fresh period is never a zero interval.
    a_fresh_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_period_fresh) |-> (m_period_us != '0))
        else $error("fresh period of zero");

    // Running faults leave the block in the error mode.
    a_fault_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == hsc_pkg::STATUS_OVERVOLT ||
                     m_status == hsc_pkg::STATUS_OVERCURR ||
                     m_status == hsc_pkg::STATUS_BAD_HALL)) |->
        (m_mode_now == hsc_pkg::MODE_ERR && !m_drive_on))
        else $error("fault reported without error mode");

    // A stop word leaves the state machine stopped.
    a_stop_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item_reg.kind == hsc_pkg::KIND_STOP) |=>
        (state_reg.mode == hsc_pkg::MODE_STOP))
        else $error("stop word did not stop the motor");
`endif

endmodule

FILE: verif/hall_six_step_commutator_test.sv
`timescale 1ns / 100ps

module hall_six_step_commutator_test;

    import hsc_pkg::*;

    // Event kind and register index that the block has no use for.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] CFG_SPARE   = 2'd3;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int PRINTED_REPORTS = 200;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;

    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index = '0;
    adc_t          cfg_data  = '0;

    logic          s_valid     = 1'b0;
    logic          s_ready;
    logic [1:0]    s_kind      = '0;
    hall_t         s_hall_code = '0;
    time_t         s_time_us   = '0;
    adc_t          s_volt_a    = '0;
    adc_t          s_volt_b    = '0;
    adc_t          s_volt_c    = '0;
    adc_t          s_amp_a     = '0;
    adc_t          s_amp_b     = '0;
    adc_t          s_amp_c     = '0;

    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [2:0]    m_status;
    logic [2:0]    m_mode_now;
    logic [2:0]    m_step_now;
    logic [1:0]    m_high_phase;
    logic [1:0]    m_low_phase;
    logic          m_drive_on;
    time_t         m_period_us;
    logic          m_period_fresh;

    hall_six_step_commutator DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_hall_code    (s_hall_code),
        .s_time_us      (s_time_us),
        .s_volt_a       (s_volt_a),
        .s_volt_b       (s_volt_b),
        .s_volt_c       (s_volt_c),
        .s_amp_a        (s_amp_a),
        .s_amp_b        (s_amp_b),
        .s_amp_c        (s_amp_c),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_mode_now     (m_mode_now),
        .m_step_now     (m_step_now),
        .m_high_phase   (m_high_phase),
        .m_low_phase    (m_low_phase),
        .m_drive_on     (m_drive_on),
        .m_period_us    (m_period_us),
        .m_period_fresh (m_period_fresh)
    );

    always #2 aclk = ~aclk;

    // Shadow of the commutator: registers and motor state as the block should hold them.
    cfg_t    cfg_shadow = '{forward_direction: 1'b1, voltage_limit: '1, current_limit: '1};
    mode_t   mdl_mode        = MODE_IDLE;
    step_t   mdl_step        = '0;
    hall_t   mdl_last_hall   = '0;
    time_t   mdl_last_change = '0;
    time_t   mdl_period      = '0;

    item_t   pending_events [$];
    result_t expected_bridge_words [$];
    item_t   word_on_bus;
    result_t oldest_bridge_word;

    int      source_idle_pct = 0;
    int      sink_idle_pct   = 0;
    int      n_queued        = 0;
    int      n_accepted      = 0;
    int      n_checked       = 0;
    int      n_reg_writes    = 0;
    int      mismatches      = 0;
    int      cycle_count     = 0;
    int      status_tally [5];
    time_t   t_clock         = '0;

    // Hall codes in rotor order; position i is forward step i.
    function automatic hall_t hall_at(int pos);
        hall_t code;
        case (pos)
            0:       code = 3'b011;
            1:       code = 3'b001;
            2:       code = 3'b101;
            3:       code = 3'b100;
            4:       code = 3'b110;
            default: code = 3'b010;
        endcase
        return code;
    endfunction

    function automatic logic hall_is_valid(hall_t code);
        return code != HALL_ALL_LOW && code != HALL_ALL_HIGH;
    endfunction

    // The reverse table is the forward one moved back by one step.
    function automatic step_t step_for_hall(hall_t code, logic fwd);
        int pos = 0;
        for (int i = 0; i < 6; i++) begin
            if (hall_at(i) == code) begin
                pos = i;
            end
        end
        return fwd ? step_t'(pos) : step_t'((pos + 5) % 6);
    endfunction

    // Works out the result word for one event and advances the shadow state.
    function automatic result_t commutate_model(item_t w);
        result_t r;
        status_t st;
        logic    fresh;
        logic    drive;
        time_t   gap;
        st    = STATUS_OK;
        fresh = 1'b0;
        drive = 1'b0;
        case (w.kind)
            KIND_START: begin
                mdl_step = '0;
                mdl_mode = MODE_ALIGN;
                drive    = 1'b1;
                if (hall_is_valid(w.hall_code)) begin
                    mdl_step        = step_for_hall(w.hall_code, cfg_shadow.forward_direction);
                    mdl_last_hall   = w.hall_code;
                    mdl_last_change = w.time_us;
                    mdl_mode        = MODE_RUN;
                end else begin
                    st = STATUS_START_FAIL;
                end
            end
            KIND_STOP: begin
                mdl_mode = MODE_STOP;
            end
            KIND_SAMPLE: begin
                if (mdl_mode == MODE_RUN) begin
                    // Phases A to C, voltage ahead of current within a phase.
                    for (int p = 0; p < 3; p++) begin
                        if (st == STATUS_OK) begin
                            if (w.volt[p] > cfg_shadow.voltage_limit) begin
                                st = STATUS_OVERVOLT;
                            end else if (w.amp[p] > cfg_shadow.current_limit) begin
                                st = STATUS_OVERCURR;
                            end
                        end
                    end
                    if (st != STATUS_OK) begin
                        mdl_mode = MODE_ERR;
                    end else begin
                        if (w.hall_code != mdl_last_hall) begin
                            gap = w.time_us - mdl_last_change;
                            if (gap != '0) begin
                                mdl_period = gap;
                                fresh      = 1'b1;
                            end
                            mdl_last_change = w.time_us;
                            mdl_last_hall   = w.hall_code;
                            if (hall_is_valid(w.hall_code)) begin
                                mdl_step = step_for_hall(w.hall_code,
                                                         cfg_shadow.forward_direction);
                            end else begin
                                st       = STATUS_BAD_HALL;
                                mdl_mode = MODE_ERR;
                            end
                        end
                        drive = (mdl_mode == MODE_RUN);
                    end
                end
            end
            default: begin
            end
        endcase
        status_tally[st]++;
        r.status       = st;
        r.mode_now     = mdl_mode;
        r.step_now     = mdl_step;
        // High side is A, A, B, B, C, C over the steps; low side is B, C, C, A, A, B.
        r.high_phase   = drive ? phase_t'(mdl_step >> 1) : '0;
        r.low_phase    = drive ? phase_t'(((mdl_step + 1) / 2 + 1) % 3) : '0;
        r.drive_on     = drive;
        r.period_us    = mdl_period;
        r.period_fresh = fresh;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        // Past 200 lines more detail does not help; the count goes on.
        if (mismatches <= PRINTED_REPORTS) begin
            $display("[%0t] result word %0d: %s", $realtime, n_checked, what);
        end
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    task automatic queue_event(logic [1:0] kind, hall_t hall, time_t t,
                               adc_t va, adc_t vb, adc_t vc,
                               adc_t aa, adc_t ab, adc_t ac);
        item_t w;
        w.kind      = kind;
        w.hall_code = hall;
        w.time_us   = t;
        w.volt[0]   = va;
        w.volt[1]   = vb;
        w.volt[2]   = vc;
        w.amp[0]    = aa;
        w.amp[1]    = ab;
        w.amp[2]    = ac;
        pending_events.push_back(w);
        n_queued++;
    endtask

    // Register write; the shadow copy follows once the block has taken it.
    task automatic write_register(logic [1:0] index, adc_t value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_reg_writes++;
        case (index)
            CFG_FWD_DIR:    cfg_shadow.forward_direction = value[0];
            CFG_VOLT_LIMIT: cfg_shadow.voltage_limit     = value;
            CFG_AMP_LIMIT:  cfg_shadow.current_limit     = value;
            default: begin
            end
        endcase
    endtask

    task automatic wait_until_drained();
        while (n_accepted != n_queued || expected_bridge_words.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Mostly within the limit, now and then anywhere in the converter range.
    function automatic adc_t sample_level(adc_t lim);
        adc_t v;
        if ($urandom_range(99) < 95) begin
            v = adc_t'($urandom_range(0, lim));
        end else begin
            v = adc_t'($urandom_range(0, 4095));
        end
        return v;
    endfunction

    // Moves the free-running microsecond clock: usual gaps, repeats and long jumps.
    function automatic time_t next_stamp();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) begin
            t_clock = t_clock + time_t'($urandom_range(1, 20000));
        end else if (roll < 90) begin
            t_clock = t_clock + time_t'($urandom());
        end
        return t_clock;
    endfunction

    // One spin of the motor: a start, hall edges in rotor order with random content,
    // occasional glitches, and often a stop at the end.
    task automatic queue_motor_run(int n_samples);
        int    pos;
        int    dir;
        int    roll;
        hall_t code;
        adc_t  vl;
        adc_t  al;
        vl   = cfg_shadow.voltage_limit;
        al   = cfg_shadow.current_limit;
        pos  = $urandom_range(5);
        dir  = $urandom_range(1) ? 1 : 5;
        code = hall_at(pos);
        if ($urandom_range(99) < 5) begin
            code = $urandom_range(1) ? HALL_ALL_LOW : HALL_ALL_HIGH;
        end
        queue_event(KIND_START, code, next_stamp(), adc_t'($urandom()), adc_t'($urandom()),
                    adc_t'($urandom()), adc_t'($urandom()), adc_t'($urandom()),
                    adc_t'($urandom()));
        for (int n = 0; n < n_samples; n++) begin
            roll = $urandom_range(99);
            if (roll < 65) begin
                pos  = (pos + dir) % 6;
                code = hall_at(pos);
            end else if (roll < 85) begin
                code = hall_at(pos);
            end else if (roll < 92) begin
                code = hall_t'($urandom_range(7));
            end else begin
                pos  = (pos + 2 * dir) % 6;
                code = hall_at(pos);
            end
            queue_event(KIND_SAMPLE, code, next_stamp(),
                        sample_level(vl), sample_level(vl), sample_level(vl),
                        sample_level(al), sample_level(al), sample_level(al));
        end
        roll = $urandom_range(99);
        if (roll < 40) begin
            queue_event(KIND_STOP, hall_t'($urandom_range(7)), next_stamp(),
                        '0, '0, '0, '0, '0, '0);
        end else if (roll < 50) begin
            queue_event(KIND_UNUSED, hall_t'($urandom_range(7)), next_stamp(),
                        '1, '1, '1, '1, '1, '1);
        end
    endtask

    // Anything the fields allow, in any mode.
    task automatic queue_noise();
        repeat ($urandom_range(1, 3)) begin
            queue_event(2'($urandom_range(3)), hall_t'($urandom_range(7)), time_t'($urandom()),
                        adc_t'($urandom()), adc_t'($urandom()), adc_t'($urandom()),
                        adc_t'($urandom()), adc_t'($urandom()), adc_t'($urandom()));
        end
    endtask

    task automatic queue_random_words(int n_words);
        int first;
        first = n_queued;
        while (n_queued - first < n_words) begin
            if ($urandom_range(9) == 0) begin
                queue_noise();
            end else begin
                queue_motor_run($urandom_range(3, 40));
            end
        end
    endtask

    // Event source: predicts each word as it is taken, then offers the next one.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_bridge_words.push_back(commutate_model(word_on_bus));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_events.size() != 0 && $urandom_range(99) >= source_idle_pct) begin
                    word_on_bus = pending_events.pop_front();
                    s_valid     <= 1'b1;
                    s_kind      <= word_on_bus.kind;
                    s_hall_code <= word_on_bus.hall_code;
                    s_time_us   <= word_on_bus.time_us;
                    s_volt_a    <= word_on_bus.volt[0];
                    s_volt_b    <= word_on_bus.volt[1];
                    s_volt_c    <= word_on_bus.volt[2];
                    s_amp_a     <= word_on_bus.amp[0];
                    s_amp_b     <= word_on_bus.amp[1];
                    s_amp_c     <= word_on_bus.amp[2];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Bridge command sink: every word taken is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_bridge_words.size() == 0) begin
                    report_mismatch("arrived with no prediction waiting");
                end else begin
                    oldest_bridge_word = expected_bridge_words.pop_front();
                    compare_field("status", m_status, oldest_bridge_word.status);
                    compare_field("mode_now", m_mode_now, oldest_bridge_word.mode_now);
                    compare_field("step_now", m_step_now, oldest_bridge_word.step_now);
                    compare_field("high_phase", m_high_phase, oldest_bridge_word.high_phase);
                    compare_field("low_phase", m_low_phase, oldest_bridge_word.low_phase);
                    compare_field("drive_on", m_drive_on, oldest_bridge_word.drive_on);
                    compare_field("period_us", m_period_us, oldest_bridge_word.period_us);
                    compare_field("period_fresh", m_period_fresh,
                                  oldest_bridge_word.period_fresh);
                end
                n_checked++;
            end
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog on the cycle count.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run stopped after %0d cycles with %0d words still expected.",
                 cycle_count, expected_bridge_words.size());
        $display("hall_six_step_commutator: mismatch");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed events, forward table, limits in mid range.
        source_idle_pct = 23;
        sink_idle_pct   = 73;
        write_register(CFG_FWD_DIR, 12'd1);
        write_register(CFG_VOLT_LIMIT, 12'd2000);
        write_register(CFG_AMP_LIMIT, 12'd3000);
        // Samples and the unused kind do nothing while idle; a start on 0 or 7 fails.
        queue_event(KIND_SAMPLE, 3'd5, 32'd10, '1, '1, '1, '1, '1, '1);
        queue_event(KIND_UNUSED, HALL_ALL_HIGH, '1, '1, '1, '1, '1, '1, '1);
        queue_event(KIND_START, HALL_ALL_LOW, 32'd20, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_START, HALL_ALL_HIGH, 32'd30, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_SAMPLE, 3'd3, 32'd40, '1, '1, '1, '1, '1, '1);
        // Good start, then a full forward turn: equal limits pass, zero gap, two wraps.
        queue_event(KIND_START, 3'd3, 32'd100, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_SAMPLE, 3'd3, 32'd150, 12'd2000, 12'd2000, 12'd2000,
                    12'd3000, 12'd3000, 12'd3000);
        queue_event(KIND_SAMPLE, 3'd1, 32'd250, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_SAMPLE, 3'd5, 32'd250, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_SAMPLE, 3'd4, 32'd50, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_SAMPLE, 3'd6, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_SAMPLE, 3'd2, 32'd5, '0, '0, '0, '0, '0, '0);
        // Invalid hall edge while running.
        queue_event(KIND_SAMPLE, HALL_ALL_HIGH, 32'd9, '0, '0, '0, '0, '0, '0);
        // Fault order: A voltage, then A current ahead of B voltage, then B ahead of C.
        queue_event(KIND_START, 3'd2, 32'd30, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_SAMPLE, 3'd2, 32'd40, 12'd2001, '0, '0, '1, '0, '0);
        queue_event(KIND_START, 3'd6, 32'd50, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_SAMPLE, 3'd6, 32'd60, '0, '1, '0, 12'd3001, '0, '0);
        queue_event(KIND_START, 3'd4, 32'd70, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_SAMPLE, 3'd4, 32'd80, '0, '0, 12'd2001, '0, 12'd3001, '0);
        // Unused kind while running, a late current fault, stop, and a failed restart.
        queue_event(KIND_START, 3'd5, 32'd100, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_UNUSED, 3'd1, 32'd110, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_SAMPLE, 3'd1, 32'd120, '0, '0, '0, '0, '0, '1);
        queue_event(KIND_STOP, 3'd3, 32'd130, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_START, HALL_ALL_LOW, 32'd150, '0, '0, '0, '0, '0, '0);
        wait_until_drained();

        // Reverse table with both limits at zero.
        write_register(CFG_FWD_DIR, 12'd0);
        write_register(CFG_VOLT_LIMIT, 12'd0);
        write_register(CFG_AMP_LIMIT, 12'd0);
        queue_event(KIND_START, 3'd1, 32'd0, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_SAMPLE, 3'd3, 32'd0, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_SAMPLE, 3'd2, 32'd1000, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_SAMPLE, 3'd6, 32'd2000, '0, '0, '0, '0, '0, '0);
        queue_event(KIND_SAMPLE, 3'd4, 32'd2001, 12'd1, '0, '0, '0, '0, '0);
        wait_until_drained();

        // Random spins, reverse table, limits just under full scale; the source
        // holds off halfway until every word has come back.
        write_register(CFG_SPARE, adc_t'($urandom()));
        write_register(CFG_FWD_DIR, 12'd0);
        write_register(CFG_VOLT_LIMIT, 12'd3900);
        write_register(CFG_AMP_LIMIT, 12'd3800);
        t_clock = time_t'($urandom());
        queue_random_words(250);
        wait_until_drained();
        queue_random_words(250);
        wait_until_drained();

        // Forward table, limits at full scale, idling swapped.
        source_idle_pct = 73;
        sink_idle_pct   = 23;
        write_register(CFG_FWD_DIR, 12'd1);
        write_register(CFG_VOLT_LIMIT, 12'd4095);
        write_register(CFG_AMP_LIMIT, 12'd4095);
        queue_random_words(500);
        wait_until_drained();

        // Random settings, both sides at full rate.
        source_idle_pct = 0;
        sink_idle_pct   = 0;
        write_register(CFG_FWD_DIR, adc_t'($urandom_range(1)));
        write_register(CFG_VOLT_LIMIT, adc_t'($urandom_range(3000, 4095)));
        write_register(CFG_AMP_LIMIT, adc_t'($urandom_range(3000, 4095)));
        queue_random_words(500);
        wait_until_drained();
        repeat (6) @(posedge aclk);

        $display("Checked %0d result words over %0d register writes in %0d cycles.",
                 n_checked, n_reg_writes, cycle_count);
        $display("Status seen: ok %0d, overvoltage %0d, overcurrent %0d, bad hall %0d, %s %0d.",
                 status_tally[STATUS_OK], status_tally[STATUS_OVERVOLT],
                 status_tally[STATUS_OVERCURR], status_tally[STATUS_BAD_HALL],
                 "failed start", status_tally[STATUS_START_FAIL]);
        if (mismatches == 0) begin
            $display("hall_six_step_commutator: match");
        end else begin
            $display("hall_six_step_commutator: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/hsc_pkg.sv
hw/rtl/hsc_core.sv
hw/rtl/hall_six_step_commutator.sv
verif/hall_six_step_commutator_test.sv
